// File: rtl/core/dtc_pkg.sv
// Shared types and constants for the trouble code table.
`default_nettype none
package dtc_pkg;
    localparam int CMD_W = 3;
    localparam logic [2:0] CMD_SET   = 3'd0;
    localparam logic [2:0] CMD_CLEAR = 3'd1;
    localparam logic [2:0] CMD_CLRALL = 3'd2;
    localparam logic [2:0] CMD_DM1   = 3'd3;
    localparam logic [2:0] CMD_DM2   = 3'd4;

    localparam logic [2:0] STS_OK      = 3'd0;
    localparam logic [2:0] STS_FULL    = 3'd1;
    localparam logic [2:0] STS_NOTFND  = 3'd2;
    localparam logic [2:0] STS_SMALL   = 3'd3;
    localparam logic [2:0] STS_NOTDUE  = 3'd4;

    localparam logic [1:0] ES_FREE = 2'd0;
    localparam logic [1:0] ES_CONF = 2'd1;
    localparam logic [1:0] ES_STOR = 2'd2;

    localparam logic [15:0] PERIOD_DEFAULT = 16'd1000;
    localparam logic [7:0] LAMP_ON = 8'hC0;
    localparam logic [31:0] NO_DTC_WORD = 32'hFFFF_FFFF;
    localparam logic [7:0] OCC_MAX = 8'd255;

    // one table entry as held in the memory
    typedef struct packed {
        logic [18:0] spn;
        logic [4:0]  fmi;
        logic [1:0]  lamp;
        logic [7:0]  occ;
    } entry_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [18:0] spn;
        logic [4:0]  fmi;
        logic [1:0]  lamp;
        logic [63:0] now;
        logic [7:0]  max_bytes;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] word;
        logic [7:0]  message_length;
        logic        last;
        logic [3:0]  active_count;
        logic [3:0]  stored_count;
        logic [1:0]  highest_lamp;
    } out_item_t;
endpackage
`default_nettype wire

// File: rtl/core/dtc_if.sv
// Valid/ready channel interfaces for commands, results and configuration.
`default_nettype none
interface dtc_in_if import dtc_pkg::*; ();
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dtc_out_if import dtc_pkg::*; ();
    logic      valid;
    logic      ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface dtc_cfg_if ();
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dtc_mem.sv
// Entry memory: one write port, one registered read port.
`default_nettype none
module dtc_mem
    import dtc_pkg::*;
#(
    parameter int IDX_W = 3
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [IDX_W-1:0] waddr,
    input  wire entry_t           wdata,
    input  wire logic [IDX_W-1:0] raddr,
    output entry_t                rdata
);
    entry_t mem [2**IDX_W];

    // write and read in one clocked block
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/diagnostic_trouble_code_table_unit.sv
// Top level: fault code table sequencer with DM1/DM2 message builder.
//
// channel | dir | transaction
// cmd     | in  | one command with key, lamp, time and buffer room
// res     | out | one result word, one or more per build command
// cfg     | in  | DM1 period in ms, zero means 1000
//
// Set and clear scan the table with one memory read per cycle, then pass
// through write back (S_WB) and output (S_OUT); clear_all and unused codes
// go straight to write back. Builds: a header word, or a single NOTDUE or
// SMALL status word, then each listed entry is found by walking the table
// slots (S_LIST) and sent from the registered read (S_EMIT); an empty list
// adds one filler word. A command is taken only when idle with the output
// register empty; res.ready low holds the current word and stalls the walk.
// Reset frees all entries, clears counts and DM1 timing, restores the period.
`default_nettype none
module diagnostic_trouble_code_table_unit
    import dtc_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input wire logic clk,
    input wire logic rst_n,
    dtc_in_if.sink   cmd,
    dtc_out_if.source res,
    dtc_cfg_if.sink  cfg
);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_SCAN = 8'b00000010,
        S_WB   = 8'b00000100,
        S_OUT  = 8'b00001000,
        S_HEAD = 8'b00010000,
        S_LIST = 8'b00100000,
        S_EMIT = 8'b01000000,
        S_FILL = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [15:0] period_reg, period_next;
    logic [63:0] last_time_reg, last_time_next;
    logic        dm1_sent_reg, dm1_sent_next;
    logic [1:0]  status_reg [MAX_ENTRIES];
    logic [1:0]  status_next [MAX_ENTRIES];
    logic [1:0]  lamp_reg [MAX_ENTRIES];
    logic [1:0]  lamp_next [MAX_ENTRIES];
    logic [CNT_W-1:0] conf_reg, conf_next, stor_reg, stor_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic        rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic        found_reg, found_next;
    logic [IDX_W-1:0] hit_reg, hit_next;
    entry_t      ent_reg, ent_next;
    logic [2:0]  sts_reg, sts_next;
    logic [63:0] elapsed_reg, elapsed_next;
    logic [7:0]  len_reg, len_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    logic        we;
    logic [IDX_W-1:0] waddr, raddr;
    entry_t      wdata, rdata;

    dtc_mem #(.IDX_W(IDX_W)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // highest lamp among confirmed entries
    logic [1:0] hl;
    always_comb
    begin
        hl = 2'd0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (status_reg[i] == ES_CONF && lamp_reg[i] > hl)
            begin
                hl = lamp_reg[i];
            end
        end
    end

    // lowest free slot
    logic free_ok;
    logic [IDX_W-1:0] free_idx;
    always_comb
    begin
        free_ok = 1'b0;
        free_idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (status_reg[i] == ES_FREE)
            begin
                free_ok = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    logic out_free;
    assign out_free = !out_valid_reg || res.ready;
    assign cmd.ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg.ready = 1'b1;
    assign res.valid = out_valid_reg;
    assign res.payload = out_reg;

    logic [1:0] want;
    assign want = (item_reg.command == CMD_DM1) ? ES_CONF : ES_STOR;

    logic rd_match;
    assign rd_match = rd_valid_reg && status_reg[rd_idx_reg] != ES_FREE
                      && rdata.spn == item_reg.spn && rdata.fmi == item_reg.fmi;

    // DM1 period in microseconds
    logic [25:0] dm1_limit;
    assign dm1_limit = 26'(period_reg) * 26'd1000;

    // result payload builder
    function automatic out_item_t mk(input logic [2:0] st, input logic [31:0] w,
                                     input logic [7:0] len, input logic lst,
                                     input logic [CNT_W-1:0] a,
                                     input logic [CNT_W-1:0] s,
                                     input logic [1:0] h);
        out_item_t o;
        o.status = st;
        o.word = w;
        o.message_length = len;
        o.last = lst;
        o.active_count = 4'(a);
        o.stored_count = 4'(s);
        o.highest_lamp = h;
        return o;
    endfunction

    // count listed entries ahead of building so length is known
    logic [7:0] msg_len;
    logic [CNT_W-1:0] nwant;
    logic [7:0] fit;
    logic [7:0] lcnt8;
    logic [CNT_W-1:0] lcnt;
    always_comb
    begin
        nwant = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (status_reg[i] == want)
            begin
                nwant = nwant + CNT_W'(1);
            end
        end
        fit = (item_reg.max_bytes - 8'd4) >> 2;
        lcnt8 = (8'(nwant) < fit) ? 8'(nwant) : fit;
        lcnt = CNT_W'(lcnt8);
        msg_len = (lcnt8 == 8'd0) ? 8'd8 : 8'd4 + {lcnt8[5:0], 2'b00};
    end

    logic [31:0] head_word;
    assign head_word = {(hl == 2'd2) ? LAMP_ON : 8'h00,
                        (hl == 2'd3) ? LAMP_ON : 8'h00,
                        (hl == 2'd3) ? LAMP_ON : 8'h00,
                        (hl == 2'd1 || hl == 2'd2) ? LAMP_ON : 8'h00};

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        item_next = item_reg;
        period_next = period_reg;
        last_time_next = last_time_reg;
        dm1_sent_next = dm1_sent_reg;
        status_next = status_reg;
        lamp_next = lamp_reg;
        conf_next = conf_reg;
        stor_next = stor_reg;
        idx_next = idx_reg;
        rd_valid_next = rd_valid_reg;
        rd_idx_next = rd_idx_reg;
        found_next = found_reg;
        hit_next = hit_reg;
        ent_next = ent_reg;
        sts_next = sts_reg;
        elapsed_next = elapsed_reg;
        len_next = len_reg;
        left_next = left_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        we = 1'b0;
        waddr = hit_reg;
        wdata = ent_reg;
        raddr = idx_reg;

        // configuration write
        if (cfg.valid && cfg.ready)
        begin
            period_next = (cfg.data == 16'd0) ? PERIOD_DEFAULT : cfg.data;
        end
        // drop the word once taken
        if (out_valid_reg && res.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && cmd.ready)
                begin
                    item_next = cmd.payload;
                    idx_next = '0;
                    rd_valid_next = 1'b0;
                    found_next = 1'b0;
                    elapsed_next = cmd.payload.now - last_time_reg;
                    if (cmd.payload.command == CMD_SET || cmd.payload.command == CMD_CLEAR)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (cmd.payload.command == CMD_DM1
                             || cmd.payload.command == CMD_DM2)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end
            S_SCAN:
            begin
                // one read issued and one read checked per cycle
                rd_valid_next = 1'b1;
                rd_idx_next = idx_reg;
                if (idx_reg != LAST_IDX)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
                if (rd_match && !found_reg)
                begin
                    found_next = 1'b1;
                    hit_next = rd_idx_reg;
                    ent_next = rdata;
                end
                if (rd_valid_reg && rd_idx_reg == LAST_IDX)
                begin
                    rd_valid_next = 1'b0;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                // modify status and counts; set and clear write the entry back
                state_next = S_OUT;
                sts_next = STS_OK;
                case (item_reg.command)
                    CMD_SET:
                    begin
                        if (found_reg)
                        begin
                            if (status_reg[hit_reg] == ES_STOR)
                            begin
                                stor_next = stor_reg - CNT_W'(1);
                                conf_next = conf_reg + CNT_W'(1);
                            end
                            status_next[hit_reg] = ES_CONF;
                            we = 1'b1;
                            waddr = hit_reg;
                            wdata = ent_reg;
                            if (ent_reg.occ != OCC_MAX)
                            begin
                                wdata.occ = ent_reg.occ + 8'd1;
                            end
                            if (item_reg.lamp > ent_reg.lamp)
                            begin
                                wdata.lamp = item_reg.lamp;
                                lamp_next[hit_reg] = item_reg.lamp;
                            end
                        end
                        else if (free_ok)
                        begin
                            status_next[free_idx] = ES_CONF;
                            lamp_next[free_idx] = item_reg.lamp;
                            conf_next = conf_reg + CNT_W'(1);
                            we = 1'b1;
                            waddr = free_idx;
                            wdata.spn = item_reg.spn;
                            wdata.fmi = item_reg.fmi;
                            wdata.lamp = item_reg.lamp;
                            wdata.occ = 8'd1;
                        end
                        else
                        begin
                            sts_next = STS_FULL;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        if (found_reg)
                        begin
                            if (status_reg[hit_reg] == ES_CONF)
                            begin
                                conf_next = conf_reg - CNT_W'(1);
                                stor_next = stor_reg + CNT_W'(1);
                            end
                            status_next[hit_reg] = ES_STOR;
                            lamp_next[hit_reg] = 2'd0;
                            we = 1'b1;
                            waddr = hit_reg;
                            wdata = ent_reg;
                            wdata.lamp = 2'd0;
                        end
                        else
                        begin
                            sts_next = STS_NOTFND;
                        end
                    end
                    CMD_CLRALL:
                    begin
                        for (int i = 0; i < MAX_ENTRIES; i++)
                        begin
                            status_next[i] = ES_FREE;
                            lamp_next[i] = 2'd0;
                        end
                        conf_next = '0;
                        stor_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = mk(sts_reg, 32'd0, 8'd0, 1'b1, conf_reg, stor_reg, hl);
                    state_next = S_IDLE;
                end
            end
            S_HEAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (item_reg.command == CMD_DM1 && dm1_sent_reg
                        && elapsed_reg < 64'(dm1_limit))
                    begin
                        out_next = mk(STS_NOTDUE, 32'd0, 8'd0, 1'b1, conf_reg, stor_reg, hl);
                        state_next = S_IDLE;
                    end
                    else if (item_reg.max_bytes < 8'd8)
                    begin
                        out_next = mk(STS_SMALL, 32'd0, 8'd0, 1'b1, conf_reg, stor_reg, hl);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (item_reg.command == CMD_DM1)
                        begin
                            last_time_next = item_reg.now;
                            dm1_sent_next = 1'b1;
                        end
                        out_next = mk(STS_OK,
                                      (item_reg.command == CMD_DM1) ? head_word : 32'd0,
                                      msg_len, 1'b0, conf_reg, stor_reg, hl);
                        len_next = msg_len;
                        left_next = lcnt;
                        idx_next = '0;
                        state_next = (lcnt == '0) ? S_FILL : S_LIST;
                    end
                end
            end
            S_LIST:
            begin
                // skip entries not of the listed kind; a hit reads its entry
                if (status_reg[idx_reg] == want)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            S_EMIT:
            begin
                // read data holds while the address holds
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = mk(STS_OK,
                                  {rdata.occ, rdata.spn[18:16], rdata.fmi, rdata.spn[15:0]},
                                  len_reg, left_reg == CNT_W'(1), conf_reg, stor_reg, hl);
                    left_next = left_reg - CNT_W'(1);
                    idx_next = idx_reg + IDX_W'(1);
                    state_next = (left_reg == CNT_W'(1)) ? S_IDLE : S_LIST;
                end
            end
            S_FILL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next = mk(STS_OK, NO_DTC_WORD, len_reg, 1'b1, conf_reg, stor_reg, hl);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            item_reg <= '0;
            period_reg <= PERIOD_DEFAULT;
            last_time_reg <= '0;
            dm1_sent_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                status_reg[i] <= ES_FREE;
                lamp_reg[i] <= 2'd0;
            end
            conf_reg <= '0;
            stor_reg <= '0;
            idx_reg <= '0;
            rd_valid_reg <= 1'b0;
            rd_idx_reg <= '0;
            found_reg <= 1'b0;
            hit_reg <= '0;
            ent_reg <= '0;
            sts_reg <= STS_OK;
            elapsed_reg <= '0;
            len_reg <= '0;
            left_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            item_reg <= item_next;
            period_reg <= period_next;
            last_time_reg <= last_time_next;
            dm1_sent_reg <= dm1_sent_next;
            status_reg <= status_next;
            lamp_reg <= lamp_next;
            conf_reg <= conf_next;
            stor_reg <= stor_next;
            idx_reg <= idx_next;
            rd_valid_reg <= rd_valid_next;
            rd_idx_reg <= rd_idx_next;
            found_reg <= found_next;
            hit_reg <= hit_next;
            ent_reg <= ent_next;
            sts_reg <= sts_next;
            elapsed_reg <= elapsed_next;
            len_reg <= len_next;
            left_reg <= left_next;
            out_valid_reg <= out_valid_next;
            out_reg <= out_next;
        end
    end
endmodule
`default_nettype wire
